FILE: rtl/lrcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_pkg: shared constants and types of the ramp-fed byte ring
// Sizes, reciprocal constant for the ramp slope, and the command record
// that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package lrcf_pkg;

  // Ring size; positions 0 .. RING_SLOTS-2 are used
  localparam int RING_SLOTS = 64;
  // Number of steps in one ramp
  localparam int RAMP_STEPS = 50;

  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam int CNT_W = $clog2(RAMP_STEPS + 1);
  localparam int GAP_W = (IDX_W > 8) ? IDX_W : 8;

  // Rounded-up reciprocal of RAMP_STEPS; exact quotient for any 8-bit dividend
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2 ** RECIP_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Function codes on the input tuser
  localparam logic [1:0] FUNC_RAMP = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;

  typedef enum logic [1:0] {
    KIND_RAMP,
    KIND_POP,
    KIND_STAT
  } lrcf_kind_e;

  typedef struct packed {
    lrcf_kind_e  kind;
    logic        rising;
    logic [7:0]  target;
    logic [7:0]  start;
    logic [7:0]  limit;
    logic [7:0]  diff;
    logic [7:0]  quot;     // diff / RAMP_STEPS
  } lrcf_cmd_t;

  typedef struct packed {
    logic [7:0] pop_data;
    logic       within_distance;
    logic       is_full;
    logic       is_empty;
  } lrcf_res_t;

endpackage

FILE: rtl/lrcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_front: request intake and classification
// Decode each beat into a command, work out the ramp span and its slope
// quotient, and hold up to two commands for the back part.
// ----------------------------------------------------------------------------
module lrcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [1:0]          s_func_i,
  input  logic [7:0]          s_target_i,
  input  logic [7:0]          s_start_i,
  input  logic [7:0]          s_limit_i,
  output logic                cmd_valid_o,
  output lrcf_pkg::lrcf_cmd_t cmd_o,
  input  logic                cmd_ready_i
);

  lrcf_pkg::lrcf_cmd_t               cmd_in;
  lrcf_pkg::lrcf_cmd_t               queue_q [2];
  logic                              wr_ptr_q, rd_ptr_q;
  logic [1:0]                        count_q;
  logic [8+lrcf_pkg::RECIP_W-1:0]    prod;
  logic                              push, pop;

  always_comb begin
    cmd_in        = '0;
    cmd_in.rising = s_target_i > s_start_i;
    cmd_in.target = s_target_i;
    cmd_in.start  = s_start_i;
    cmd_in.limit  = s_limit_i;
    cmd_in.diff   = cmd_in.rising ? (s_target_i - s_start_i) : (s_start_i - s_target_i);
    prod          = {{lrcf_pkg::RECIP_W{1'b0}}, cmd_in.diff} *
                    (8 + lrcf_pkg::RECIP_W)'(lrcf_pkg::RECIP);
    cmd_in.quot   = prod[lrcf_pkg::RECIP_SHIFT +: 8];
    case (s_func_i)
      lrcf_pkg::FUNC_RAMP: begin
        // a ramp between equal levels pushes nothing
        cmd_in.kind = (s_target_i != s_start_i) ? lrcf_pkg::KIND_RAMP : lrcf_pkg::KIND_STAT;
      end
      lrcf_pkg::FUNC_POP: begin
        cmd_in.kind = lrcf_pkg::KIND_POP;
      end
      default: begin
        cmd_in.kind = lrcf_pkg::KIND_STAT;
      end
    endcase
  end

  assign s_ready_o   = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd_in;
  end

endmodule

FILE: rtl/lrcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_back: ramp engine, byte ring and result register
// Run one command at a time: step the ramp one push per cycle, pop the
// front byte, and load the status result into the output register.
// ----------------------------------------------------------------------------
module lrcf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lrcf_pkg::lrcf_cmd_t cmd_i,
  output logic                cmd_ready_o,
  output logic                res_valid_o,
  output lrcf_pkg::lrcf_res_t res_o,
  input  logic                res_ready_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RAMP  = 3'd2;
  localparam logic [2:0] ST_POP   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [lrcf_pkg::IDX_W-1:0] LAST_IDX = lrcf_pkg::IDX_W'(lrcf_pkg::RING_SLOTS - 2);
  localparam logic [lrcf_pkg::CNT_W-1:0] LAST_CNT = lrcf_pkg::CNT_W'(lrcf_pkg::RAMP_STEPS);
  localparam logic [8:0]                 STEPS9   = 9'(lrcf_pkg::RAMP_STEPS);

  logic [2:0]                   state_q;
  lrcf_pkg::lrcf_cmd_t          cmd_q;
  logic [lrcf_pkg::CNT_W-1:0]   cnt_q;
  logic [7:0]                   r0_q, step_q, rem_q;
  logic [lrcf_pkg::IDX_W-1:0]   head_q, tail_q;
  logic                         empty_q, pop_hit_q;
  logic [7:0]                   rd_q;
  logic [7:0]                   ring_mem [lrcf_pkg::RING_SLOTS];
  logic                         res_valid_q;
  lrcf_pkg::lrcf_res_t          res_q;

  logic [15:0]                  q_prod;
  logic [8:0]                   rem_sum;
  logic                         wrap;
  logic [7:0]                   step_n, rem_n, ramp_val, push_data;
  logic                         full, push_we, load_res;
  logic [lrcf_pkg::IDX_W-1:0]   tail_next, head_next, wr_idx, gap;
  lrcf_pkg::lrcf_res_t          res_d;

  // Slope remainder: diff - quot * RAMP_STEPS
  assign q_prod = {8'd0, cmd_q.quot} * 16'(lrcf_pkg::RAMP_STEPS);

  // Advance floor(i * diff / RAMP_STEPS) by quotient plus remainder carry
  always_comb begin
    rem_sum  = {1'b0, rem_q} + {1'b0, r0_q};
    wrap     = rem_sum >= STEPS9;
    rem_n    = wrap ? 8'(rem_sum - STEPS9) : rem_sum[7:0];
    step_n   = step_q + cmd_q.quot + {7'd0, wrap};
    ramp_val = cmd_q.rising ? (cmd_q.start + step_n) : (cmd_q.start - step_n);
    push_data = (cnt_q == LAST_CNT) ? cmd_q.target : ramp_val;
  end

  always_comb begin
    full      = !empty_q && ((head_q == tail_q + lrcf_pkg::IDX_W'(1)) ||
                             (head_q == '0 && tail_q == LAST_IDX));
    tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + lrcf_pkg::IDX_W'(1);
    head_next = (head_q == LAST_IDX) ? '0 : head_q + lrcf_pkg::IDX_W'(1);
    wr_idx    = empty_q ? '0 : tail_next;
    push_we   = (state_q == ST_RAMP) && !full;
    gap       = tail_q - head_q;
  end

  always_comb begin
    res_d                 = '0;
    res_d.pop_data        = pop_hit_q ? rd_q : 8'd0;
    res_d.is_empty        = empty_q;
    res_d.is_full         = full;
    res_d.within_distance = empty_q || !((tail_q > head_q) &&
                            (lrcf_pkg::GAP_W'(gap) > lrcf_pkg::GAP_W'(cmd_q.limit)));
  end

  assign load_res    = (state_q == ST_DONE) && (!res_valid_q || res_ready_i);
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      pop_hit_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (load_res)         res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            pop_hit_q <= 1'b0;
            case (cmd_i.kind)
              lrcf_pkg::KIND_RAMP: state_q <= ST_SETUP;
              lrcf_pkg::KIND_POP:  state_q <= ST_POP;
              default:             state_q <= ST_DONE;
            endcase
          end
        end
        ST_SETUP: begin
          cnt_q   <= lrcf_pkg::CNT_W'(1);
          state_q <= ST_RAMP;
        end
        ST_RAMP: begin
          // drop the byte while the ring is full
          if (push_we) begin
            empty_q <= 1'b0;
            tail_q  <= wr_idx;
            if (empty_q) head_q <= '0;
          end
          if (cnt_q == LAST_CNT) state_q <= ST_DONE;
          else                   cnt_q   <= cnt_q + lrcf_pkg::CNT_W'(1);
        end
        ST_POP: begin
          if (!empty_q) begin
            pop_hit_q <= 1'b1;
            if (head_q == tail_q) begin
              empty_q <= 1'b1;
              head_q  <= '0;
              tail_q  <= '0;
            end else begin
              head_q <= head_next;
            end
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load_res) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == ST_SETUP) begin
      r0_q   <= cmd_q.diff - q_prod[7:0];
      step_q <= 8'd0;
      rem_q  <= 8'd0;
    end
    if (state_q == ST_RAMP) begin
      step_q <= step_n;
      rem_q  <= rem_n;
    end
    if (load_res) res_q <= res_d;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_we) ring_mem[wr_idx] <= push_data;
    if (state_q == ST_POP) rd_q <= ring_mem[head_q];
  end

endmodule

FILE: rtl/linear_ramp_into_circular_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_ramp_into_circular_fifo: ramp generator feeding a byte ring
// Top level: stream intake, command queue, ramp engine and result port.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream s_axis: one beat per request. tuser carries the function
//   (ramp, pop, status), tdata the target level, start level and distance
//   limit. Master stream m_axis: exactly one result beat per request, in
//   order: the popped byte on tdata, the empty, full and distance flags on
//   tuser.
//   A ramp between differing levels pushes RAMP_STEPS-1 intermediate bytes
//   and then the target, one push per cycle; bytes that meet a full ring
//   are dropped. The ring holds at most RING_SLOTS-1 bytes.
// Sequence
//   A ramp passes the back engine through take-up, slope setup, one push
//   per cycle through the single ring write port, and result load; a pop
//   through take-up, a registered ring read and result load; a status
//   query or a ramp between equal levels through take-up and result load.
//   A query beat taken on an idle block goes via the queue to the result register.
// Reset and stall
//   Reset empties the ring at once (no clearing pass) and drops queued
//   requests. A stalled receiver holds the result register; the two-entry
//   command queue keeps taking beats until it fills, then tready falls.
// ----------------------------------------------------------------------------
module linear_ramp_into_circular_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // target_value, start_value, distance_limit
  input  logic [1:0]  s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // pop_data
  output logic [2:0]  m_axis_tuser_o    // is_empty, is_full, within_distance
);

  logic                cmd_valid, cmd_ready;
  lrcf_pkg::lrcf_cmd_t cmd;
  lrcf_pkg::lrcf_res_t res;

  // Front: take beats, classify, queue
  lrcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_func_i    (s_axis_tuser_i),
    .s_target_i  (s_axis_tdata_i[7:0]),
    .s_start_i   (s_axis_tdata_i[15:8]),
    .s_limit_i   (s_axis_tdata_i[23:16]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Back: run ramps and pops on the ring, hold the result beat
  lrcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  // Pack the result beat, lowest field first
  assign m_axis_tdata_o = res.pop_data;
  assign m_axis_tuser_o = {res.within_distance, res.is_full, res.is_empty};

endmodule

FILE: rtl/lrcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrcf_checker: port-level checks for the ramp-fed byte ring
// Watch the result stream for flag combinations the ring cannot produce.
// ----------------------------------------------------------------------------
module lrcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
    && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // An empty ring is never full
  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("empty and full together");

  // An empty ring always passes the distance check
  a_empty_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[2])
    else $error("empty ring failed distance check");

  // A pop leaves room, so a full result carries no popped byte
  a_full_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == 8'd0)
    else $error("full result with popped byte");

  // No result while in reset, nor on the cycle after release
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result beat straight after reset");

endmodule

bind linear_ramp_into_circular_fifo lrcf_checker u_lrcf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
